>>> sv/gcsr_pkg.sv
`default_nettype none

package gcsr_pkg;

	// Readout geometry
	localparam int BITS_PER_COLOR = 12;
	localparam int COLOR_COUNT    = 3;
	localparam int BIT_IDX_W      = $clog2(BITS_PER_COLOR + 1);
	localparam int WORD_IDX_W     = $clog2(COLOR_COUNT + 1);

	// Field and counter widths
	localparam int COLOR_W    = 12;
	localparam int MS_W       = 16;
	localparam int US_W       = 20;
	localparam int WAIT_W     = 27;
	localparam int HOLD_W     = 16;
	localparam int TICK_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Microseconds in one millisecond of integration time
	localparam int US_PER_MS = 1000;

	// Longest run of back-to-back actions that one tick can chain
	localparam int ACTION_CHAIN = 6;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_AFTER_GATE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_BETWEEN_WORDS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_RANGE_SETTLE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_BEFORE_RANGE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HIGH_TICKS   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CLOCK_LOW_TICKS    = 3'd5;

	// Register reset values
	localparam logic [HOLD_W-1:0] RST_HOLD_AFTER_GATE    = 16'd4;
	localparam logic [HOLD_W-1:0] RST_HOLD_BETWEEN_WORDS = 16'd3;
	localparam logic [HOLD_W-1:0] RST_HOLD_RANGE_SETTLE  = 16'd2000;
	localparam logic [HOLD_W-1:0] RST_HOLD_BEFORE_RANGE  = 16'd3;
	localparam logic [TICK_W-1:0] RST_CLOCK_HIGH_TICKS   = 8'd1;
	localparam logic [TICK_W-1:0] RST_CLOCK_LOW_TICKS    = 8'd1;

	// Sequencer phase codes
	localparam logic [3:0] PH_IDLE       = 4'd0;
	localparam logic [3:0] PH_RANGE      = 4'd1;
	localparam logic [3:0] PH_GATE_ON    = 4'd2;
	localparam logic [3:0] PH_GATE_OFF   = 4'd3;
	localparam logic [3:0] PH_READ_START = 4'd4;
	localparam logic [3:0] PH_SAMPLE     = 4'd5;
	localparam logic [3:0] PH_BIT_NEXT   = 4'd6;
	localparam logic [3:0] PH_WORD_NEXT  = 4'd7;
	localparam logic [3:0] PH_FINISH     = 4'd8;

	// One microsecond tick with the sensor data sample
	typedef struct packed {
		logic            start_req;
		logic            range_high;
		logic [MS_W-1:0] integration_ms;
		logic [US_W-1:0] integration_us;
		logic            data_in;
	} in_item_t;

	// Pin levels and readings after the tick
	typedef struct packed {
		logic               range_pin;
		logic               gate_pin;
		logic               clock_pin;
		logic               busy_res;
		logic               done_res;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} out_item_t;

endpackage

`default_nettype wire

>>> sv/gated_color_sensor_readout_unit.sv
// Channel   Direction  Handshake                    Carries
// sample    in         sample_valid / sample_ready  one microsecond tick with data pin level
// result    out        result_valid / result_ready  pin levels and readings after that tick
// cfg       in         cfg_we                       register write, cfg_idx / cfg_data
//
// One request is taken every cycle while the result register is free or being emptied.
// It waits in the input register, and its result is written to the result register by
// the combinational sequencer step, which chains up to ACTION_CHAIN due actions of one tick.
// The asynchronous reset clears the sequencer and loads the register defaults.
// While a result waits in the output register, one more request is held at the input.

`default_nettype none

module gated_color_sensor_readout_unit (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 sample_valid,
	output logic                                sample_ready,
	input  gcsr_pkg::in_item_t                  sample,
	output logic                                result_valid,
	input  wire                                 result_ready,
	output gcsr_pkg::out_item_t                 result,
	input  wire                                 cfg_we,
	input  wire  [gcsr_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  wire  [gcsr_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import gcsr_pkg::*;

	typedef logic [BITS_PER_COLOR-1:0] word_t;
	typedef word_t [COLOR_COUNT-1:0] word_arr_t;

	typedef struct packed {
		logic [HOLD_W-1:0] hold_after_gate;
		logic [HOLD_W-1:0] hold_between_words;
		logic [HOLD_W-1:0] hold_range_settle;
		logic [HOLD_W-1:0] hold_before_range;
		logic [TICK_W-1:0] clock_high_ticks;
		logic [TICK_W-1:0] clock_low_ticks;
	} cfg_t;

	typedef struct packed {
		logic [3:0]            phase;
		logic [WAIT_W-1:0]     wait_cnt;
		logic [BIT_IDX_W-1:0]  bit_idx;
		logic [WORD_IDX_W-1:0] word_idx;
		word_t                 shift;
		word_arr_t             pend;
		word_arr_t             color;
		logic                  range_lat;
		logic                  req_range;
		logic [WAIT_W-1:0]     integ;
		logic                  gate;
		logic                  clk_lvl;
		logic                  done;
	} seq_t;

	cfg_t              cfg_q;
	seq_t              seq_q;
	seq_t              nxt;
	in_item_t          item_s1;
	logic              valid_s1;
	out_item_t         result_s2;
	logic              res_valid_s2;
	logic              advance;
	logic [WAIT_W-1:0] integ_time;
	out_item_t         res_next;

	// OR the data level into the bits from one position upwards.
	function automatic word_t fill_from(input word_t w, input logic [BIT_IDX_W-1:0] from,
		input logic d);
		word_t r;
		r = w;
		for (int i = 0; i < BITS_PER_COLOR; i++) begin
			if (i >= int'(from)) begin
				r[i] = w[i] | d;
			end
		end
		return r;
	endfunction

	// Start clocking a new word: clock high, first bit.
	function automatic seq_t begin_word(input seq_t s, input cfg_t c);
		seq_t r;
		r = s;
		r.bit_idx  = '0;
		r.shift    = '0;
		r.clk_lvl  = 1'b1;
		r.phase    = PH_SAMPLE;
		r.wait_cnt = WAIT_W'(c.clock_high_ticks);
		return r;
	endfunction

	// One action of the sequence. With both clock phases zero a whole word is
	// taken at once, and with no hold between words all remaining words too.
	function automatic seq_t run_action(input seq_t s, input cfg_t c, input logic d);
		seq_t  r;
		word_t filled;
		logic  fast;
		r      = s;
		fast   = (c.clock_high_ticks == '0) && (c.clock_low_ticks == '0);
		filled = fill_from(s.shift, s.bit_idx, d);
		case (s.phase)
			PH_RANGE: begin
				r.range_lat = s.req_range;
				r.phase     = PH_GATE_ON;
				r.wait_cnt  = WAIT_W'(c.hold_range_settle);
			end
			PH_GATE_ON: begin
				r.gate     = 1'b1;
				r.phase    = PH_GATE_OFF;
				r.wait_cnt = s.integ;
			end
			PH_GATE_OFF: begin
				r.gate     = 1'b0;
				r.phase    = PH_READ_START;
				r.wait_cnt = WAIT_W'(c.hold_after_gate);
			end
			PH_READ_START: begin
				r.word_idx = '0;
				r = begin_word(r, c);
			end
			PH_SAMPLE: begin
				r.clk_lvl = 1'b0;
				if (!fast) begin
					for (int i = 0; i < BITS_PER_COLOR; i++) begin
						if (i == int'(s.bit_idx)) begin
							r.shift[i] = s.shift[i] | d;
						end
					end
					r.phase    = PH_BIT_NEXT;
					r.wait_cnt = WAIT_W'(c.clock_low_ticks);
				end else begin
					r.bit_idx = BIT_IDX_W'(BITS_PER_COLOR);
					r.shift   = filled;
					for (int k = 0; k < COLOR_COUNT; k++) begin
						if (k == int'(s.word_idx)) begin
							r.pend[k] = filled;
						end
					end
					if (c.hold_between_words != '0) begin
						r.phase    = PH_WORD_NEXT;
						r.wait_cnt = WAIT_W'(c.hold_between_words);
					end else begin
						for (int k = 0; k < COLOR_COUNT; k++) begin
							if (k > int'(s.word_idx)) begin
								r.pend[k] = {BITS_PER_COLOR{d}};
							end
						end
						if (int'(s.word_idx) + 1 < COLOR_COUNT) begin
							r.shift = {BITS_PER_COLOR{d}};
						end
						r.word_idx = WORD_IDX_W'(COLOR_COUNT);
						r.phase    = PH_FINISH;
						r.wait_cnt = WAIT_W'(c.hold_range_settle);
					end
				end
			end
			PH_BIT_NEXT: begin
				r.bit_idx = s.bit_idx + BIT_IDX_W'(1);
				if (r.bit_idx < BIT_IDX_W'(BITS_PER_COLOR)) begin
					r.clk_lvl  = 1'b1;
					r.phase    = PH_SAMPLE;
					r.wait_cnt = WAIT_W'(c.clock_high_ticks);
				end else begin
					for (int k = 0; k < COLOR_COUNT; k++) begin
						if (k == int'(s.word_idx)) begin
							r.pend[k] = s.shift;
						end
					end
					r.phase    = PH_WORD_NEXT;
					r.wait_cnt = WAIT_W'(c.hold_between_words);
				end
			end
			PH_WORD_NEXT: begin
				r.word_idx = s.word_idx + WORD_IDX_W'(1);
				if (r.word_idx < WORD_IDX_W'(COLOR_COUNT)) begin
					r = begin_word(r, c);
				end else begin
					r.phase    = PH_FINISH;
					r.wait_cnt = WAIT_W'(c.hold_range_settle);
				end
			end
			PH_FINISH: begin
				r.color    = s.pend;
				r.done     = 1'b1;
				r.phase    = PH_IDLE;
				r.wait_cnt = '0;
			end
			default: begin
				r.phase    = PH_IDLE;
				r.wait_cnt = '0;
			end
		endcase
		return r;
	endfunction

	// A stored word as a twelve-bit reading; absent colours read zero.
	function automatic logic [COLOR_W-1:0] color_out(input word_arr_t c, input int idx);
		logic [COLOR_W-1:0] r;
		r = '0;
		for (int k = 0; k < COLOR_COUNT; k++) begin
			if (k == idx) begin
				for (int b = 0; b < COLOR_W; b++) begin
					if (b < BITS_PER_COLOR) begin
						r[b] = c[k][b % BITS_PER_COLOR];
					end
				end
			end
		end
		return r;
	endfunction

	// Handshake: the step advances when the result register is free or being emptied.
	assign advance      = valid_s1 && (!res_valid_s2 || result_ready);
	assign sample_ready = !valid_s1 || advance;
	assign result_valid = res_valid_s2;
	assign result       = result_s2;

	// Integration time in ticks for a new measurement.
	assign integ_time = WAIT_W'({{(WAIT_W - MS_W){1'b0}}, item_s1.integration_ms}
		* WAIT_W'(US_PER_MS)) + WAIT_W'(item_s1.integration_us);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_after_gate    <= RST_HOLD_AFTER_GATE;
			cfg_q.hold_between_words <= RST_HOLD_BETWEEN_WORDS;
			cfg_q.hold_range_settle  <= RST_HOLD_RANGE_SETTLE;
			cfg_q.hold_before_range  <= RST_HOLD_BEFORE_RANGE;
			cfg_q.clock_high_ticks   <= RST_CLOCK_HIGH_TICKS;
			cfg_q.clock_low_ticks    <= RST_CLOCK_LOW_TICKS;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_HOLD_AFTER_GATE:    cfg_q.hold_after_gate    <= cfg_data;
				REG_HOLD_BETWEEN_WORDS: cfg_q.hold_between_words <= cfg_data;
				REG_HOLD_RANGE_SETTLE:  cfg_q.hold_range_settle  <= cfg_data;
				REG_HOLD_BEFORE_RANGE:  cfg_q.hold_before_range  <= cfg_data;
				REG_CLOCK_HIGH_TICKS:   cfg_q.clock_high_ticks   <= cfg_data[TICK_W-1:0];
				REG_CLOCK_LOW_TICKS:    cfg_q.clock_low_ticks    <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	// One tick of the sequencer: start or count down, then run up to ACTION_CHAIN due actions.
	always_comb begin
		nxt      = seq_q;
		nxt.done = 1'b0;
		if (seq_q.phase == PH_IDLE) begin
			if (item_s1.start_req) begin
				nxt.req_range = item_s1.range_high;
				nxt.integ     = integ_time;
				nxt.gate      = 1'b0;
				nxt.clk_lvl   = 1'b0;
				nxt.phase     = PH_RANGE;
				nxt.wait_cnt  = WAIT_W'(cfg_q.hold_before_range);
			end
		end else if (seq_q.wait_cnt != '0) begin
			nxt.wait_cnt = seq_q.wait_cnt - WAIT_W'(1);
		end
		for (int u = 0; u < ACTION_CHAIN; u++) begin
			if (nxt.phase != PH_IDLE && nxt.wait_cnt == '0) begin
				nxt = run_action(nxt, cfg_q, item_s1.data_in);
			end
		end
	end

	// Result fields shown after the tick.
	always_comb begin
		res_next.range_pin = nxt.range_lat;
		res_next.gate_pin  = nxt.gate;
		res_next.clock_pin = nxt.clk_lvl;
		res_next.busy_res  = (nxt.phase != PH_IDLE);
		res_next.done_res  = nxt.done;
		res_next.red       = color_out(nxt.color, 0);
		res_next.green     = color_out(nxt.color, 1);
		res_next.blue      = color_out(nxt.color, 2);
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_valid && sample_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			item_s1 <= sample;
		end
	end

	// Sequencer state; the all-zero state is the idle phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= '0;
		end else if (advance) begin
			seq_q <= nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= 1'b1;
		end else if (result_ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= res_next;
		end
	end

endmodule

`default_nettype wire

>>> sv/gcsr_checker.sv
`default_nettype none

module gcsr_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 sample_valid,
	input wire                 sample_ready,
	input wire                 result_valid,
	input wire                 result_ready,
	input gcsr_pkg::out_item_t result
);
	import gcsr_pkg::*;

	// A stalled result holds its value.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// With the output register empty, a request can always be taken.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> sample_ready)
		else $error("input stalled with empty output");

	// Completion marks the end of a sequence.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.done_res |-> !result.busy_res)
		else $error("done raised while still busy");

	// The readout clock only runs while the gate is closed.
	a_gate_clock: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.gate_pin |-> !result.clock_pin)
		else $error("gate and clock high together");

endmodule

bind gated_color_sensor_readout_unit gcsr_checker u_gcsr_checker (.*);

`default_nettype wire
